[hdl/hpr_pkg.sv]
// Package for the reading-progress percentile rank block.
// Holds sizes, word widths, the controller state type and the command and status structs.
// Depends on nothing; every other file of the block imports it.
package hpr_pkg;

    // Store sizes.
    localparam int MAX_USERS = 131072;
    localparam int MAX_PAGES = 1024;

    // Field widths of the input and result words.
    localparam int UID_W  = 17;
    localparam int PAGE_W = 10;
    localparam int RANK_W = 17;

    // Address widths of the two stores.
    localparam int USER_AW = $clog2(MAX_USERS);
    localparam int HIST_AW = $clog2(MAX_PAGES);

    // Datapath widths.
    localparam int BIN_W   = 18;
    localparam int SUM_W   = BIN_W + HIST_AW;
    localparam int QCNT_W  = HIST_AW + 1;
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = BIN_W + FRAC_W;
    localparam int DCNT_W  = $clog2(DVD_W + 1);

    // Clearing pass covers the larger of the two stores.
    localparam int CLEAR_N = (MAX_USERS > MAX_PAGES) ? MAX_USERS : MAX_PAGES;
    localparam int CLR_W   = $clog2(CLEAR_N);

    // One in Q1.16.
    localparam logic [RANK_W-1:0] Q_ONE = RANK_W'(1 << FRAC_W);

    // Word kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OLD_WR,
        ST_NEW_RD,
        ST_NEW_WR,
        ST_SUM,
        ST_DIV,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic user_wr;
        logic total_inc;
        logic hist_rd_old;
        logic old_wr;
        logic hist_rd_new;
        logic new_wr;
        logic sum_init;
        logic sum_run;
        logic div_start;
        logic res_zero;
        logic res_one;
        logic res_quot;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic is_query;
        logic uid_ok;
        logic pages_ok;
        logic old_zero;
        logic total_le1;
        logic sum_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

[hdl/hpr_div.sv]
// Bit-serial restoring divider for the rank fraction, one quotient bit per cycle.
// Depends on hpr_pkg for widths.
module hpr_div
    import hpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [BIN_W-1:0]  divisor,
    output logic              done,
    output logic [RANK_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [BIN_W-1:0]  rem_reg, rem_next;
    logic [BIN_W-1:0]  dsr_reg, dsr_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [RANK_W-1:0] quo_reg, quo_next;
    logic [BIN_W:0]    shifted;
    logic [BIN_W:0]    diff;

    // Shift in the next dividend bit and try the subtraction.
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DVD_W);
            rem_next  = '0;
            dsr_next  = divisor;
            dvd_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (!diff[BIN_W])
            begin
                rem_next = diff[BIN_W-1:0];
                quo_next = {quo_reg[RANK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[BIN_W-1:0];
                quo_next = {quo_reg[RANK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/hpr_datapath.sv]
// Datapath of the percentile rank block: user and histogram memories, reader total,
// suffix accumulator, result register and the divider. Depends on hpr_pkg and hpr_div.
module hpr_datapath
    import hpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           st,
    input  logic              kind,
    input  logic [UID_W-1:0]  user_id,
    input  logic [PAGE_W-1:0] pages_read,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RANK_W-1:0] rank_fraction
);

    logic [PAGE_W-1:0] user_mem [MAX_USERS];
    logic [BIN_W-1:0]  hist_mem [MAX_PAGES];

    logic              kind_reg;
    logic [UID_W-1:0]  uid_reg;
    logic [PAGE_W-1:0] pages_reg;
    logic [PAGE_W-1:0] user_rdata_reg;
    logic [BIN_W-1:0]  hist_rdata_reg;
    logic [BIN_W-1:0]  total_reg;
    logic [SUM_W-1:0]  suffix_reg;
    logic [QCNT_W-1:0] q_reg;
    logic              pend_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;
    logic [RANK_W-1:0] res_reg;
    logic [RANK_W-1:0] out_data_reg;
    logic              out_valid_reg;

    logic               user_we;
    logic [USER_AW-1:0] user_wa;
    logic [PAGE_W-1:0]  user_wd;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_wa;
    logic [BIN_W-1:0]   hist_wd;
    logic               hist_re;
    logic [HIST_AW-1:0] hist_ra;
    logic               sum_rd;
    logic               clr_user;
    logic               clr_hist;
    logic [BIN_W-1:0]   fewer;
    logic               div_done;
    logic [RANK_W-1:0]  quotient;

    // Clearing pass reaches each store only over its own depth.
    assign clr_user = cmd.clear_step && (32'(clr_cnt_reg) < MAX_USERS);
    assign clr_hist = cmd.clear_step && (32'(clr_cnt_reg) < MAX_PAGES);
    assign sum_rd   = cmd.sum_run && (32'(q_reg) < MAX_PAGES);

    // User store write port.
    always_comb
    begin
        user_we = clr_user || cmd.user_wr;
        if (cmd.clear_step)
        begin
            user_wa = USER_AW'(clr_cnt_reg);
            user_wd = '0;
        end
        else
        begin
            user_wa = USER_AW'(uid_reg);
            user_wd = pages_reg;
        end
    end

    // Histogram write and read ports.
    always_comb
    begin
        hist_we = clr_hist || cmd.old_wr || cmd.new_wr;
        if (cmd.clear_step)
        begin
            hist_wa = HIST_AW'(clr_cnt_reg);
            hist_wd = '0;
        end
        else if (cmd.old_wr)
        begin
            hist_wa = HIST_AW'(user_rdata_reg);
            hist_wd = hist_rdata_reg - BIN_W'(hist_rdata_reg != '0);
        end
        else
        begin
            hist_wa = HIST_AW'(pages_reg);
            hist_wd = hist_rdata_reg + BIN_W'(1);
        end
        hist_re = cmd.hist_rd_old || cmd.hist_rd_new || sum_rd;
        if (cmd.hist_rd_old)
        begin
            hist_ra = HIST_AW'(user_rdata_reg);
        end
        else if (cmd.hist_rd_new)
        begin
            hist_ra = HIST_AW'(pages_reg);
        end
        else
        begin
            hist_ra = q_reg[HIST_AW-1:0];
        end
    end

    // User store: the lookup read is issued at the edge that accepts the word.
    always_ff @(posedge clk)
    begin
        if (user_we)
        begin
            user_mem[user_wa] <= user_wd;
        end
        if (cmd.capture)
        begin
            user_rdata_reg <= user_mem[USER_AW'(user_id)];
        end
    end

    // Histogram store.
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_ra];
        end
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            uid_reg   <= user_id;
            pages_reg <= pages_read;
        end
    end

    // Suffix sum: one bin read per cycle, each bin added in the cycle after its read.
    always_ff @(posedge clk)
    begin
        if (cmd.sum_init)
        begin
            suffix_reg <= '0;
        end
        else if (pend_reg)
        begin
            suffix_reg <= suffix_reg + SUM_W'(hist_rdata_reg);
        end
    end

    // Control registers: reader total, sweep counters and the result slot flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            q_reg         <= '0;
            pend_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.total_inc)
            begin
                total_reg <= total_reg + BIN_W'(1);
            end
            if (cmd.sum_init)
            begin
                q_reg <= QCNT_W'(user_rdata_reg);
            end
            else if (sum_rd)
            begin
                q_reg <= q_reg + QCNT_W'(1);
            end
            pend_reg <= sum_rd;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result and output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.res_zero)
        begin
            res_reg <= '0;
        end
        else if (cmd.res_one)
        begin
            res_reg <= Q_ONE;
        end
        else if (cmd.res_quot)
        begin
            res_reg <= quotient;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // Readers behind the user; a suffix above the total gives none.
    assign fewer = (suffix_reg > SUM_W'(total_reg)) ? '0
                 : total_reg - suffix_reg[BIN_W-1:0];

    hpr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({fewer, FRAC_W'(0)}),
        .divisor  (total_reg - BIN_W'(1)),
        .done     (div_done),
        .quotient (quotient)
    );

    // Status towards the controller.
    always_comb
    begin
        st.clear_done = (clr_cnt_reg == CLR_W'(CLEAR_N - 1));
        st.is_query   = (kind_reg == KIND_QUERY);
        st.uid_ok     = (32'(uid_reg) < MAX_USERS);
        st.pages_ok   = (pages_reg != '0) && (32'(pages_reg) < MAX_PAGES);
        st.old_zero   = (user_rdata_reg == '0);
        st.total_le1  = (total_reg <= BIN_W'(1));
        st.sum_done   = (q_reg == QCNT_W'(MAX_PAGES)) && !pend_reg;
        st.div_done   = div_done;
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign rank_fraction = out_data_reg;

    // The divider starts only on a finished suffix sum.
    a_div_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> st.sum_done)
        else $error("divider started before the suffix sum finished");

    // The suffix does not exceed the reader total when the divider starts.
    a_suffix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (suffix_reg <= SUM_W'(total_reg)))
        else $error("suffix sum above reader total");

    // The reader total only ever grows.
    a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("reader total decreased");

    // No update of either store overlaps the clearing pass.
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !(cmd.user_wr || cmd.old_wr || cmd.new_wr || cmd.capture))
        else $error("store update during clearing pass");

endmodule

[hdl/hpr_ctrl.sv]
// Controller state machine of the percentile rank block.
// Depends on hpr_pkg for the state type and the command and status structs.
module hpr_ctrl
    import hpr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!st.is_query)
                begin
                    // A valid read word moves the user from the old bin to the new one, or adds a first-time reader.
                    if (st.uid_ok && st.pages_ok)
                    begin
                        cmd.user_wr = 1'b1;
                        if (st.old_zero)
                        begin
                            cmd.total_inc = 1'b1;
                            state_next    = ST_NEW_RD;
                        end
                        else
                        begin
                            cmd.hist_rd_old = 1'b1;
                            state_next      = ST_OLD_WR;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // A query settles at once for unknown users and a sole reader.
                    if (!st.uid_ok || st.old_zero)
                    begin
                        cmd.res_zero = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    else if (st.total_le1)
                    begin
                        cmd.res_one = 1'b1;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        cmd.sum_init = 1'b1;
                        state_next   = ST_SUM;
                    end
                end
            end
            ST_OLD_WR:
            begin
                cmd.old_wr = 1'b1;
                state_next = ST_NEW_RD;
            end
            ST_NEW_RD:
            begin
                cmd.hist_rd_new = 1'b1;
                state_next      = ST_NEW_WR;
            end
            ST_NEW_WR:
            begin
                cmd.new_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (st.sum_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.res_quot = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[hdl/histogram_percentile_rank.sv]
// Reading-progress percentile rank: per-user page counts, a page histogram and a reader
// total, with rank queries answered as an unsigned Q1.16 fraction. After reset the block
// runs a clearing pass over the user store and the histogram with in_ready low.
// Words are taken one at a time. A read word with a zero or out-of-range page count is
// ignored; otherwise the histogram memory is updated by read-modify-write: for a reader
// that moves between bins the old bin is read and decremented, then the new bin is read
// and incremented. A rank query sums the histogram bins from the user's page count
// upward, one bin read per cycle, then a restoring divider produces one quotient bit
// per cycle. Queries for unknown users or a sole reader skip the sum and the division.
// A finished result waits in an output register, and the next word is accepted while it
// waits.
module histogram_percentile_rank
    import hpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [UID_W-1:0]  user_id,
    input  logic [PAGE_W-1:0] pages_read,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RANK_W-1:0] rank_fraction
);

    cmd_t    cmd;
    status_t st;

    hpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    hpr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .kind          (kind),
        .user_id       (user_id),
        .pages_read    (pages_read),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rank_fraction (rank_fraction)
    );

endmodule

[bench/histogram_percentile_rank_tb.sv]
// Self-checking testbench for the reading-progress percentile rank block.
// Drives read and rank query words, predicts every rank word and checks it; needs hpr_pkg and
// histogram_percentile_rank with hpr_ctrl, hpr_datapath and hpr_div.
`timescale 1ns / 100ps

module histogram_percentile_rank_tb;

    import hpr_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 2000;
    localparam int STALL_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 1200;
    localparam int STEADY_WORDS   = 80;
    localparam int RANDOM_WORDS   = 460;
    localparam int IDLE_PERCENT   = 31;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              kind;
    logic [UID_W-1:0]  user_id;
    logic [PAGE_W-1:0] pages_read;
    logic              out_valid;
    logic              out_ready;
    logic [RANK_W-1:0] rank_fraction;

    // Shadow copy of the block's stores.
    logic [PAGE_W-1:0] pages_of_user [int];
    logic [BIN_W-1:0]  readers_at [MAX_PAGES];
    logic [BIN_W-1:0]  readers;

    logic [RANK_W-1:0] rank_expected [$];
    logic [RANK_W-1:0] want_rank;
    int                known_users [$];
    int                mismatch_count;
    int                stall_cycles;
    int                hold_left;
    bit                steady_traffic;
    bit                hold_off_request;
    bit                hold_seen;

    histogram_percentile_rank dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .user_id       (user_id),
        .pages_read    (pages_read),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rank_fraction (rank_fraction)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    // Moves a user into the bin of the new page count; a zero count is the never-read mark
    // and leaves everything as it was.
    function automatic void note_read(input logic [UID_W-1:0] uid,
                                      input logic [PAGE_W-1:0] pg);
        logic [PAGE_W-1:0] old;
        if (int'(uid) >= MAX_USERS || pg == '0 || int'(pg) >= MAX_PAGES)
            return;
        old = pages_of_user.exists(int'(uid)) ? pages_of_user[int'(uid)] : '0;
        if (old == '0)
            readers = readers + 1'b1;
        else if (readers_at[old] != '0)
            readers_at[old] = readers_at[old] - 1'b1;
        readers_at[pg] = readers_at[pg] + 1'b1;
        pages_of_user[int'(uid)] = pg;
    endfunction

    // Share of the other readers with strictly fewer pages, Q1.16 truncated.
    function automatic logic [RANK_W-1:0] rank_of(input logic [UID_W-1:0] uid);
        logic [PAGE_W-1:0] mine;
        logic [63:0]       suffix;
        logic [63:0]       fewer;
        if (int'(uid) >= MAX_USERS)
            return '0;
        mine = pages_of_user.exists(int'(uid)) ? pages_of_user[int'(uid)] : '0;
        if (mine == '0)
            return '0;
        if (readers <= 1)
            return Q_ONE;
        suffix = '0;
        for (int q = int'(mine); q < MAX_PAGES; q++)
            suffix = suffix + 64'(readers_at[q]);
        fewer = (suffix > 64'(readers)) ? 64'd0 : 64'(readers) - suffix;
        return RANK_W'((fewer << FRAC_W) / (64'(readers) - 64'd1));
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Offers one word, holding it until accepted, then updates the prediction.
    task automatic send_word(input logic k, input logic [UID_W-1:0] uid,
                             input logic [PAGE_W-1:0] pg);
        int gap;
        gap = 0;
        if (!steady_traffic && $urandom_range(99) < IDLE_PERCENT)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        user_id    <= uid;
        pages_read <= pg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == KIND_QUERY)
            rank_expected.push_back(rank_of(uid));
        else
            note_read(uid, pg);
    endtask

    // Random word: queries and reads in equal share, queries mostly on users that have read,
    // reads partly moving known users, and a few ignored zero-page reads.
    task automatic send_random_word();
        logic              k;
        logic [UID_W-1:0]  uid;
        logic [PAGE_W-1:0] pg;
        int                reuse;
        k = ($urandom_range(1) == 1) ? KIND_QUERY : KIND_READ;
        if ($urandom_range(99) < 8)
            pg = '0;
        else
            pg = PAGE_W'($urandom_range(1, MAX_PAGES - 1));
        reuse = (k == KIND_QUERY) ? 80 : 40;
        if (known_users.size() != 0 && $urandom_range(99) < reuse)
            uid = UID_W'(known_users[$urandom_range(known_users.size() - 1)]);
        else
            uid = UID_W'($urandom_range(MAX_USERS - 1));
        if (k == KIND_READ && pg != '0)
            known_users.push_back(int'(uid));
        send_word(k, uid, pg);
    endtask

    // Receiver: random back-pressure, a long hold-off on each toggle of the request flag,
    // none in steady traffic.
    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request != hold_seen)
            begin
                hold_seen = hold_off_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= steady_traffic || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Each accepted rank word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (rank_expected.size() == 0)
            begin
                report_mismatch($sformatf("rank word 0x%0h with none predicted", rank_fraction));
            end
            else
            begin
                want_rank = rank_expected.pop_front();
                if (rank_fraction !== want_rank)
                    report_mismatch($sformatf("rank_fraction 0x%0h, predicted 0x%0h",
                                              rank_fraction, want_rank));
            end
        end
    end

    // Watchdog on cycles with no word moving on either side; covers the clearing pass.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic test_reset();
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        kind             <= KIND_READ;
        user_id          <= '0;
        pages_read       <= '0;
        steady_traffic   = 1'b0;
        hold_off_request = 1'b0;
        readers          = '0;
        foreach (readers_at[i])
            readers_at[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Edge cases: never-read user, sole reader, ignored zero-page read, lowest and highest
    // counts and user ids, moving a user between bins and rereading the same count.
    task automatic test_directed_cases();
        send_word(KIND_QUERY, UID_W'(5), '1);
        send_word(KIND_READ, UID_W'(5), PAGE_W'(MAX_PAGES - 1));
        send_word(KIND_QUERY, UID_W'(5), '0);
        send_word(KIND_READ, UID_W'(5), '0);
        send_word(KIND_QUERY, UID_W'(5), '0);
        send_word(KIND_READ, '1, PAGE_W'(1));
        send_word(KIND_QUERY, '1, '1);
        send_word(KIND_QUERY, UID_W'(5), '0);
        send_word(KIND_READ, '0, PAGE_W'(512));
        send_word(KIND_QUERY, '0, '0);
        send_word(KIND_READ, UID_W'(5), PAGE_W'(1));
        send_word(KIND_QUERY, UID_W'(5), '0);
        send_word(KIND_READ, '0, PAGE_W'(512));
        send_word(KIND_QUERY, '0, '1);
        send_word(KIND_QUERY, UID_W'(17'h0AAAA), '0);
        send_word(KIND_READ, UID_W'(17'h15555), PAGE_W'(10'h2AA));
        send_word(KIND_READ, UID_W'(17'h0AAAA), PAGE_W'(10'h155));
        send_word(KIND_QUERY, UID_W'(17'h15555), PAGE_W'(10'h155));
        send_word(KIND_QUERY, UID_W'(17'h0AAAA), PAGE_W'(10'h2AA));
        send_word(KIND_READ, UID_W'(17'h0AAAA), PAGE_W'(MAX_PAGES - 1));
        send_word(KIND_QUERY, '1, '0);
        send_word(KIND_QUERY, UID_W'(17'h0AAAA), '0);
        known_users.push_back(5);
        known_users.push_back(MAX_USERS - 1);
        known_users.push_back(0);
        known_users.push_back(17'h15555);
        known_users.push_back(17'h0AAAA);
    endtask

    // The receiver stops for a long stretch while queries keep coming, so that the
    // result register fills and the block has to hold off its input.
    task automatic test_output_backpressure();
        send_word(KIND_READ, UID_W'(17'h1F0F0), PAGE_W'(1000));
        known_users.push_back(17'h1F0F0);
        hold_off_request = ~hold_off_request;
        repeat (6)
            send_word(KIND_QUERY, UID_W'(17'h1F0F0), PAGE_W'($urandom_range(MAX_PAGES - 1)));
        send_word(KIND_READ, UID_W'(17'h1F0F0), PAGE_W'(900));
        send_word(KIND_QUERY, UID_W'(17'h1F0F0), '0);
    endtask

    // Back-to-back words with no idling on either side.
    task automatic test_steady_stream();
        steady_traffic = 1'b1;
        repeat (STEADY_WORDS)
            send_random_word();
        steady_traffic = 1'b0;
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_WORDS)
            send_random_word();
    endtask

    initial
    begin
        test_reset();
        test_directed_cases();
        test_output_backpressure();
        test_steady_stream();
        test_random_traffic();

        // Let every predicted rank word arrive, then watch for strays.
        in_valid <= 1'b0;
        while (rank_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hdl/hpr_pkg.sv
hdl/hpr_div.sv
hdl/hpr_datapath.sv
hdl/hpr_ctrl.sv
hdl/histogram_percentile_rank.sv
bench/histogram_percentile_rank_tb.sv
